// ----- hdl/rbv_pkg.sv -----
package rbv_pkg;

    localparam logic [63:0] TWO_PI_Q29   = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q40  = 64'd1727108826179;
    localparam logic [63:0] OMEGA_CAP    = 64'd1 << 45;
    localparam logic [63:0] SAT62        = 64'd1 << 62;
    localparam logic [23:0] Q_MIN_RAW    = 24'd66;
    localparam logic [31:0] FREQ_DEFAULT = 32'd2560;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_Q_FACTOR    = 1'b1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
        logic        sat;
    } t_mul_req;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] dvs;
        logic [6:0]  steps;
    } t_div_req;

endpackage

// ----- hdl/rbv_if.sv -----
interface rbv_in_if #(parameter int SAMPLE_WIDTH = 24);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] in_sample;
    logic [31:0]             center_freq;
    modport source (output valid, in_sample, center_freq, input ready);
    modport sink   (input valid, in_sample, center_freq, output ready);
endinterface

interface rbv_out_if #(parameter int SAMPLE_WIDTH = 24);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] out_sample;
    modport source (output valid, out_sample, input ready);
    modport sink   (input valid, out_sample, output ready);
endinterface

interface rbv_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rbv_mul.sv -----
module rbv_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rbv_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [63:0]       o_p
);

    logic [63:0]  r_a, r_b, r_hi, r_lo;
    logic [5:0]   r_sh;
    logic         r_sat, r_busy, r_fin;
    logic [6:0]   r_cnt;
    logic [64:0]  w_sum;
    logic [127:0] w_q;

    assign w_sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : 65'd0);
    assign w_q   = {r_hi, r_lo} >> r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_sh   <= i_req.sh;
                r_sat  <= i_req.sat;
                r_hi   <= '0;
                r_lo   <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[64:1];
                r_lo  <= {w_sum[0], r_lo[63:1]};
                r_b   <= {1'b0, r_b[63:1]};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_fin;
    assign o_p    = (r_sat && (w_q > {64'd0, rbv_pkg::SAT62})) ? rbv_pkg::SAT62 : w_q[63:0];

endmodule

// ----- hdl/rbv_div.sv -----
module rbv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rbv_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_q
);

    logic [63:0] r_rem, r_dq, r_dvs;
    logic [6:0]  r_steps, r_cnt;
    logic        r_busy, r_fin;
    logic [64:0] w_t;
    logic        w_ge;
    logic [64:0] w_sub;

    assign w_t   = {r_rem, r_dq[63]};
    assign w_ge  = w_t >= {1'b0, r_dvs};
    assign w_sub = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_rem   <= i_req.rem;
                r_dq    <= i_req.dq;
                r_dvs   <= i_req.dvs;
                r_steps <= i_req.steps;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[63:0] : w_t[63:0];
                r_dq  <= {r_dq[62:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == r_steps - 7'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_fin;
    assign o_q    = r_dq;

endmodule

// ----- hdl/resonant_bandpass_vcf.sv -----
// Each sample is worked through eleven 64-bit products on one bit-serial multiplier, three
// 64-bit quotients and one of COEF_FRAC_BITS bits on one bit-serial divider, and the steps
// S_OMRD, S_CHK and S_OUT; fewer when one-minus-r is 1 or the cosine is 0.
// One sample is worked at a time; the next sample is taken while a result waits at the output.
// Reset: synchronous active low; taps cleared, sample_rate 44100, q_factor 65536.
module resonant_bandpass_vcf #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbv_in_if.sink     i_in,
    rbv_out_if.source  o_out,
    rbv_cfg_if.sink    i_cfg
);

    localparam int          C   = COEF_FRAC_BITS;
    localparam int          DN  = (C <= 37) ? 37 - C : 0;
    localparam int          UP  = (C > 37) ? C - 37 : 0;
    localparam logic [63:0] ONE = 64'd1 << C;
    localparam logic [63:0] HALF_PI = rbv_pkg::HALF_PI_Q40 >> (40 - C);
    localparam logic [5:0]  SH  = 6'(C);
    localparam logic [6:0]  STEPS_C = 7'(C);
    localparam logic signed [65:0] TAP_MAX = (66'sd1 <<< 47) - 66'sd1;
    localparam logic signed [65:0] TAP_MIN = -(66'sd1 <<< 47);
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MF    = 5'd1;
    localparam logic [4:0] S_DOM   = 5'd2;
    localparam logic [4:0] S_OMRD  = 5'd3;
    localparam logic [4:0] S_DOMR  = 5'd4;
    localparam logic [4:0] S_CHK   = 5'd5;
    localparam logic [4:0] S_MG    = 5'd6;
    localparam logic [4:0] S_MG2   = 5'd7;
    localparam logic [4:0] S_MG3   = 5'd8;
    localparam logic [4:0] S_D24   = 5'd9;
    localparam logic [4:0] S_D720  = 5'd10;
    localparam logic [4:0] S_MC1   = 5'd11;
    localparam logic [4:0] S_MRR   = 5'd12;
    localparam logic [4:0] S_MRO   = 5'd13;
    localparam logic [4:0] S_MGAIN = 5'd14;
    localparam logic [4:0] S_MT1   = 5'd15;
    localparam logic [4:0] S_MT2   = 5'd16;
    localparam logic [4:0] S_MY    = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    logic [4:0]              r_state;
    logic                    r_go;
    logic [17:0]             r_rate;
    logic [23:0]             r_qf;
    logic [47:0]             r_tap1, r_tap2;
    logic [SAMPLE_WIDTH-1:0] r_x, r_res, r_odata;
    logic [30:0]             r_f;
    logic [63:0]             r_tmp, r_omega, r_omr, r_g, r_g2, r_g3, r_t24;
    logic [63:0]             r_cos, r_coef1, r_coef2, r_ro, r_gain, r_s1;
    logic                    r_ovalid;

    rbv_pkg::t_mul_req w_mreq;
    rbv_pkg::t_div_req w_dreq;
    logic              w_mstart, w_dstart, w_mdone, w_ddone;
    logic [63:0]       w_mp, w_dq, w_r, w_qq, w_om37, w_omega, w_s2, w_o;
    logic signed [65:0] w_y;
    logic signed [63:0] w_ys;
    logic [47:0]       w_ycl;

    assign w_r    = ONE - r_omr;
    assign w_qq   = {40'd0, r_qf} << (C - 16);
    assign w_om37 = (w_dq > rbv_pkg::OMEGA_CAP) ? rbv_pkg::OMEGA_CAP : w_dq;
    assign w_omega = (w_om37 >> DN) << UP;
    assign w_s2   = (r_coef2[63] ^ r_tap2[47]) ? (64'd0 - w_mp) : w_mp;
    assign w_y    = 66'(signed'(r_x)) + 66'(signed'(r_s1)) + 66'(signed'(w_s2));
    assign w_ycl  = (w_y > TAP_MAX) ? TAP_MAX[47:0] :
                    (w_y < TAP_MIN) ? TAP_MIN[47:0] : w_y[47:0];
    assign w_o    = (r_tap1[47] ^ r_gain[63]) ? (64'd0 - w_mp) : w_mp;
    assign w_ys   = signed'(w_o);

    always_comb begin
        w_mreq   = '0;
        w_mstart = 1'b0;
        w_mreq.sh  = SH;
        w_mreq.sat = 1'b1;
        case (r_state)
            S_MF: begin
                w_mreq.a   = {33'd0, r_f};
                w_mreq.b   = rbv_pkg::TWO_PI_Q29;
                w_mreq.sh  = 6'd0;
                w_mreq.sat = 1'b0;
            end
            S_MG: begin
                w_mreq.a = r_omega;
                w_mreq.b = r_omega;
            end
            S_MG2: begin
                w_mreq.a = r_g;
                w_mreq.b = r_g;
            end
            S_MG3: begin
                w_mreq.a = r_g2;
                w_mreq.b = r_g;
            end
            S_MC1: begin
                w_mreq.a = mag64(r_cos);
                w_mreq.b = w_r;
            end
            S_MRR: begin
                w_mreq.a = w_r;
                w_mreq.b = w_r;
            end
            S_MRO: begin
                w_mreq.a = w_r;
                w_mreq.b = r_omega;
            end
            S_MGAIN: begin
                w_mreq.a = r_omr;
                w_mreq.b = r_omr + r_ro;
            end
            S_MT1: begin
                w_mreq.a = mag64(r_coef1);
                w_mreq.b = mag64({{16{r_tap1[47]}}, r_tap1});
            end
            S_MT2: begin
                w_mreq.a = mag64(r_coef2);
                w_mreq.b = mag64({{16{r_tap2[47]}}, r_tap2});
            end
            S_MY: begin
                w_mreq.a = mag64({{16{r_tap1[47]}}, r_tap1});
                w_mreq.b = mag64(r_gain);
            end
            default: w_mreq.a = '0;
        endcase
        if (!r_go && (r_state inside {S_MF, S_MG, S_MG2, S_MG3, S_MC1, S_MRR, S_MRO,
                                      S_MGAIN, S_MT1, S_MT2, S_MY}))
            w_mstart = 1'b1;
    end

    always_comb begin
        w_dreq   = '0;
        w_dstart = 1'b0;
        w_dreq.steps = 7'd64;
        case (r_state)
            S_DOM: begin
                w_dreq.dq  = r_tmp;
                w_dreq.dvs = (r_rate == 18'd0) ? 64'd1 : {46'd0, r_rate};
            end
            S_DOMR: begin
                w_dreq.rem   = r_omega;
                w_dreq.dvs   = w_qq;
                w_dreq.steps = STEPS_C;
            end
            S_D24: begin
                w_dreq.dq  = r_g2;
                w_dreq.dvs = 64'd24;
            end
            S_D720: begin
                w_dreq.dq  = r_g3;
                w_dreq.dvs = 64'd720;
            end
            default: w_dreq.dq = '0;
        endcase
        if (!r_go && (r_state inside {S_DOM, S_DOMR, S_D24, S_D720}))
            w_dstart = 1'b1;
    end

    rbv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    rbv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_q     (w_dq)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_ovalid;
    assign o_out.out_sample = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_rate   <= 18'd44100;
            r_qf     <= 24'd65536;
            r_tap1   <= '0;
            r_tap2   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    rbv_pkg::CFG_SAMPLE_RATE: r_rate <= i_cfg.data[17:0];
                    rbv_pkg::CFG_Q_FACTOR:    r_qf   <= i_cfg.data;
                    default: r_qf <= r_qf;
                endcase
            end
            if (r_ovalid && o_out.ready && (r_state != S_OUT))
                r_ovalid <= 1'b0;
            if (w_mstart || w_dstart)
                r_go <= 1'b1;
            if (w_mdone || w_ddone)
                r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x <= i_in.in_sample;
                        r_f <= (i_in.center_freq[31] || i_in.center_freq == 32'd0) ?
                               rbv_pkg::FREQ_DEFAULT[30:0] : i_in.center_freq[30:0];
                        r_state <= S_MF;
                    end
                end
                S_MF: if (w_mdone) begin
                    r_tmp   <= w_mp;
                    r_state <= S_DOM;
                end
                S_DOM: if (w_ddone) begin
                    r_omega <= w_omega;
                    r_state <= S_OMRD;
                end
                S_OMRD: begin
                    if (r_qf < rbv_pkg::Q_MIN_RAW || r_omega >= w_qq) begin
                        r_omr   <= ONE;
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_DOMR;
                    end
                end
                S_DOMR: if (w_ddone) begin
                    r_omr   <= w_dq;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_omega <= HALF_PI) begin
                        r_state <= S_MG;
                    end else begin
                        r_cos   <= '0;
                        r_state <= S_MC1;
                    end
                end
                S_MG: if (w_mdone) begin
                    r_g     <= w_mp;
                    r_state <= S_MG2;
                end
                S_MG2: if (w_mdone) begin
                    r_g2    <= w_mp;
                    r_state <= S_MG3;
                end
                S_MG3: if (w_mdone) begin
                    r_g3    <= w_mp;
                    r_state <= S_D24;
                end
                S_D24: if (w_ddone) begin
                    r_t24   <= w_dq;
                    r_state <= S_D720;
                end
                S_D720: if (w_ddone) begin
                    r_cos   <= ONE - (r_g >> 1) + r_t24 - w_dq;
                    r_state <= S_MC1;
                end
                S_MC1: if (w_mdone) begin
                    r_coef1 <= r_cos[63] ? ((64'd0 - w_mp) << 1) : (w_mp << 1);
                    r_state <= S_MRR;
                end
                S_MRR: if (w_mdone) begin
                    r_coef2 <= 64'd0 - w_mp;
                    r_state <= S_MRO;
                end
                S_MRO: if (w_mdone) begin
                    r_ro    <= w_mp;
                    r_state <= S_MGAIN;
                end
                S_MGAIN: if (w_mdone) begin
                    r_gain  <= w_mp << 1;
                    r_state <= S_MT1;
                end
                S_MT1: if (w_mdone) begin
                    r_s1    <= (r_coef1[63] ^ r_tap1[47]) ? (64'd0 - w_mp) : w_mp;
                    r_state <= S_MT2;
                end
                S_MT2: if (w_mdone) begin
                    r_tap2  <= r_tap1;
                    r_tap1  <= w_ycl;
                    r_state <= S_MY;
                end
                S_MY: if (w_mdone) begin
                    r_res   <= (w_ys > OUT_MAX) ? OUT_MAX[SAMPLE_WIDTH-1:0] :
                               (w_ys < OUT_MIN) ? OUT_MIN[SAMPLE_WIDTH-1:0] :
                               w_ys[SAMPLE_WIDTH-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_mul_done_launched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> r_go)
        else $error("multiplier finished without a launched product");

    a_div_done_launched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_go)
        else $error("divider finished without a launched quotient");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_go)
        else $error("arithmetic unit busy while idle");

    a_no_dual_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mstart && w_dstart))
        else $error("multiplier and divider launched together");

endmodule
